### hw/rtl/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared types, constants and saturation helpers for the keyframe vector
// interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

	localparam int KEYS_DEFAULT = 16;
	localparam int QDEPTH       = 2;
	localparam int DIV_STEPS    = 49;
	localparam logic [15:0] DEFAULT_RATE = 16'd24;

	localparam logic [1:0] REG_TPS      = 2'd0;
	localparam logic [1:0] REG_DURATION = 2'd1;
	localparam logic [1:0] REG_KEYCOUNT = 2'd2;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_OOR   = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	// one classified word between front and back
	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         key_index;
		logic [31:0]        tval;      // key time for loads, tick for queries
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} entry_t;

	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -33'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/kvi_ram.sv
// ----------------------------------------------------------------------------
// kvi_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvi_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/kvi_front.sv
// ----------------------------------------------------------------------------
// kvi_front
// Accepts input words, forms the query tick and classifies each word as a
// load, an out-of-range query or a query to interpolate.
// ----------------------------------------------------------------------------
module kvi_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [3:0]           key_index,
	input  logic [31:0]          key_time,
	input  logic signed [31:0]   value_x,
	input  logic signed [31:0]   value_y,
	input  logic signed [31:0]   value_z,
	input  logic [31:0]          elapsed_time,
	input  logic [15:0]          tps,
	input  logic [31:0]          duration,
	input  logic                 q_full,
	output logic                 push,
	output kvi_pkg::entry_t      push_entry
);

	logic               valid_s1;
	logic               cmd_s1;
	logic [3:0]         idx_s1;
	logic [31:0]        ktime_s1;
	logic signed [31:0] vx_s1, vy_s1, vz_s1;
	logic [47:0]        tick_s1;
	logic [15:0]        rate;
	logic               accept;

	assign rate     = (tps == 16'd0) ? kvi_pkg::DEFAULT_RATE : tps;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			idx_s1   <= key_index;
			ktime_s1 <= key_time;
			vx_s1    <= value_x;
			vy_s1    <= value_y;
			vz_s1    <= value_z;
			tick_s1  <= elapsed_time * rate;
		end
	end

	always_comb begin
		push_entry.key_index = idx_s1;
		push_entry.vx        = vx_s1;
		push_entry.vy        = vy_s1;
		push_entry.vz        = vz_s1;
		if (!cmd_s1) begin
			push_entry.kind = kvi_pkg::KIND_LOAD;
			push_entry.tval = ktime_s1;
		end else begin
			push_entry.kind = (tick_s1 > {16'd0, duration}) ? kvi_pkg::KIND_OOR
			                                                 : kvi_pkg::KIND_QUERY;
			push_entry.tval = tick_s1[31:0];
		end
	end

endmodule

### hw/rtl/kvi_fifo.sv
// ----------------------------------------------------------------------------
// kvi_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module kvi_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kvi_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output kvi_pkg::entry_t pop_entry,
	output logic            empty
);

	localparam int PW = $clog2(kvi_pkg::QDEPTH);

	kvi_pkg::entry_t mem_q [kvi_pkg::QDEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     cnt_q;

	assign full      = (cnt_q == (PW+1)'(kvi_pkg::QDEPTH));
	assign empty     = (cnt_q == '0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(kvi_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(kvi_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

endmodule

### hw/rtl/kvi_back.sv
// ----------------------------------------------------------------------------
// kvi_back
// Executes queued words: writes keyframes, searches the key table, divides
// for the tween fraction and blends the two keys with one shared multiplier.
// ----------------------------------------------------------------------------
module kvi_back #(
	parameter int KEYS = kvi_pkg::KEYS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  kvi_pkg::entry_t    pop_entry,
	output logic               pop,
	input  logic [4:0]         key_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               in_range,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);

	localparam int AW = $clog2(KEYS);
	localparam int CW = $clog2(KEYS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1;
	localparam logic [2:0] ST_SRCH  = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_TW    = 3'd5;
	localparam logic [2:0] ST_MUL   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]         state_q;
	logic [CW-1:0]      n, b_q, b_next;
	logic [31:0]        tick_q;
	logic [127:0]       ent_a_q, ent_b_q, rdata;
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        den_q, rem_q;
	logic [48:0]        dvd_q, quo_q;
	logic               neg_q;
	logic [5:0]         dcnt_q;
	logic [32:0]        trial;
	logic signed [32:0] num;
	logic [32:0]        mag;
	logic signed [31:0] tween_q, w_q, tween_c;
	logic signed [32:0] w_wide;
	logic [2:0]         mcnt_q;
	logic [2:0]         kk_prev;
	logic [1:0]         comp_i;
	logic signed [31:0] op_v, op_f, psat, pa_q, psum;
	logic signed [63:0] p_q;
	logic               rng_q;
	logic signed [31:0] rx_q, ry_q, rz_q;

	function automatic logic signed [31:0] comp(input logic [127:0] e, input logic [1:0] c);
		logic signed [31:0] r;
		unique case (c)
			2'd0:    r = e[95:64];
			2'd1:    r = e[63:32];
			default: r = e[31:0];
		endcase
		return r;
	endfunction

	always_comb begin
		if ({27'd0, key_count} > 32'(KEYS)) begin
			n = CW'(KEYS);
		end else if (key_count == 5'd0) begin
			n = CW'(1);
		end else begin
			n = CW'(key_count);
		end
	end

	assign pop    = (state_q == ST_IDLE) && !empty;
	assign ram_we = pop && (pop_entry.kind == kvi_pkg::KIND_LOAD)
	                && ({28'd0, pop_entry.key_index} < 32'(KEYS));
	assign b_next = b_q + 1'b1;

	always_comb begin
		priority if (state_q == ST_FIRST) begin
			ram_raddr = AW'(1);
		end else if (state_q == ST_SRCH) begin
			ram_raddr = b_next[AW-1:0];
		end else begin
			ram_raddr = '0;
		end
	end

	kvi_ram #(.WIDTH(128), .DEPTH(KEYS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(pop_entry.key_index)),
		.wdata({pop_entry.tval, pop_entry.vx, pop_entry.vy, pop_entry.vz}),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// divider step and tween/weight saturation
	assign trial  = {rem_q, dvd_q[48]};
	assign num    = $signed({1'b0, tick_q}) - $signed({1'b0, ent_a_q[127:96]});
	assign mag    = num[32] ? 33'(-num) : 33'(num);
	always_comb begin
		if (!neg_q) begin
			tween_c = (quo_q > 49'd2147483647) ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
		end else begin
			tween_c = (quo_q > 49'd2147483648) ? 32'sh80000000 : $signed(-quo_q[31:0]);
		end
	end
	assign w_wide = 33'sd65536 - $signed({tween_q[31], tween_q});

	// shared multiplier operands
	assign comp_i  = 2'(mcnt_q >> 1);
	assign op_v    = mcnt_q[0] ? comp(ent_b_q, comp_i) : comp(ent_a_q, comp_i);
	assign op_f    = mcnt_q[0] ? tween_q : w_q;
	assign kk_prev = mcnt_q - 3'd1;
	assign psat    = kvi_pkg::sat48(p_q[63:16]);
	assign psum    = kvi_pkg::sat33($signed({pa_q[31], pa_q}) + $signed({psat[31], psat}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && (!out_valid || !out_stall)) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						priority if (pop_entry.kind == kvi_pkg::KIND_QUERY) begin
							state_q <= ST_FIRST;
						end else if (pop_entry.kind == kvi_pkg::KIND_OOR) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIRST: state_q <= (n == CW'(1)) ? ST_OUT : ST_SRCH;
				ST_SRCH: begin
					if (tick_q < rdata[127:96]) begin
						state_q <= ST_PREP;
					end else if (b_next >= n) begin
						state_q <= ST_OUT;
					end
				end
				ST_PREP: state_q <= (ent_b_q[127:96] <= ent_a_q[127:96]) ? ST_OUT : ST_DIV;
				ST_DIV:  state_q <= (dcnt_q == 6'(kvi_pkg::DIV_STEPS - 1)) ? ST_TW : ST_DIV;
				ST_TW:   state_q <= ST_MUL;
				ST_MUL:  state_q <= (mcnt_q == 3'd6) ? ST_OUT : ST_MUL;
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				tick_q <= pop_entry.tval;
				rng_q  <= (pop_entry.kind == kvi_pkg::KIND_QUERY);
				rx_q   <= '0;
				ry_q   <= '0;
				rz_q   <= '0;
			end
			ST_FIRST: begin
				ent_a_q <= rdata;
				b_q     <= CW'(1);
				rx_q    <= rdata[95:64];
				ry_q    <= rdata[63:32];
				rz_q    <= rdata[31:0];
			end
			ST_SRCH: begin
				if (tick_q < rdata[127:96]) begin
					ent_b_q <= rdata;
				end else begin
					ent_a_q <= rdata;
					b_q     <= b_next;
					rx_q    <= rdata[95:64];
					ry_q    <= rdata[63:32];
					rz_q    <= rdata[31:0];
				end
			end
			ST_PREP: begin
				// unordered pair: rx/ry/rz already hold key a
				den_q  <= ent_b_q[127:96] - ent_a_q[127:96];
				neg_q  <= num[32];
				dvd_q  <= {mag, 16'd0};
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				dvd_q  <= {dvd_q[47:0], 1'b0};
				dcnt_q <= dcnt_q + 6'd1;
				if (trial >= {1'b0, den_q}) begin
					rem_q <= 32'(trial - {1'b0, den_q});
					quo_q <= {quo_q[47:0], 1'b1};
				end else begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[47:0], 1'b0};
				end
			end
			ST_TW: begin
				tween_q <= tween_c;
				mcnt_q  <= '0;
			end
			ST_MUL: begin
				tween_q <= tween_q;
				w_q     <= (mcnt_q == 3'd0) ? kvi_pkg::sat33(w_wide) : w_q;
				mcnt_q  <= mcnt_q + 3'd1;
				if (mcnt_q == 3'd0) begin
					p_q <= op_v * kvi_pkg::sat33(w_wide);
				end else begin
					p_q <= op_v * op_f;
				end
				if (mcnt_q != 3'd0) begin
					if (!kk_prev[0]) begin
						pa_q <= psat;
					end else begin
						unique case (kk_prev[2:1])
							2'd0:    rx_q <= psum;
							2'd1:    ry_q <= psum;
							default: rz_q <= psum;
						endcase
					end
				end
			end
			ST_OUT: begin
				if (!out_valid || !out_stall) begin
					in_range <= rng_q;
					out_x    <= rx_q;
					out_y    <= ry_q;
					out_z    <= rz_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_div_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (den_q != 32'd0))
		else $error("divider running with zero divisor");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (out_x == 0 && out_y == 0 && out_z == 0))
		else $error("out-of-range result carries a value");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (b_q < n))
		else $error("search index reached key count");

	a_first_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRST) |-> $past(pop))
		else $error("search started without a queued query");

endmodule

### hw/rtl/keyframe_vector_interpolator_core.sv
// Operation: a load is written to the key table when the back end pops it; a query
//   scans k = 1..KEYS-1 keys, one per cycle, then runs 49 divider steps and the
//   multiplier blend; out-of-range queries skip the search, a single key the scan.
// Past the last key, or for an unordered pair, the divider and multiplier are skipped.
// The back end holds one query at a time.
// Reset: arst_n clears control and registers (tps 0, so rate 24; duration 0, key count 1).
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator_core
// Keyframe table with linear Q16.16 interpolation of a 3-component value.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator_core #(
	parameter int KEYS = kvi_pkg::KEYS_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [3:0]         key_index,
	input  logic [31:0]        key_time,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_z,
	input  logic [31:0]        elapsed_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               in_range,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [15:0]     tps_q;
	logic [31:0]     duration_q;
	logic [4:0]      key_count_q;
	logic            push, full, pop, empty;
	kvi_pkg::entry_t push_entry, pop_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= '0;
			duration_q  <= '0;
			key_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kvi_pkg::REG_TPS:      tps_q       <= cfg_data[15:0];
				kvi_pkg::REG_DURATION: duration_q  <= cfg_data;
				kvi_pkg::REG_KEYCOUNT: key_count_q <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	kvi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.key_index   (key_index),
		.key_time    (key_time),
		.value_x     (value_x),
		.value_y     (value_y),
		.value_z     (value_z),
		.elapsed_time(elapsed_time),
		.tps         (tps_q),
		.duration    (duration_q),
		.q_full      (full),
		.push        (push),
		.push_entry  (push_entry)
	);

	kvi_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.pop_entry (pop_entry),
		.empty     (empty)
	);

	kvi_back #(.KEYS(KEYS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_entry(pop_entry),
		.pop      (pop),
		.key_count(key_count_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.in_range (in_range),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z)
	);

endmodule
